// ----- hw/rtl/zoned_disk_sector_offset_assert.svh -----
// assertion macros used by the checker of this block
`ifndef ZONED_DISK_SECTOR_OFFSET_ASSERT_SVH
`define ZONED_DISK_SECTOR_OFFSET_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define ZDSO_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("zdso check failed");

// next-cycle implication, sampled on clock, off during reset
`define ZDSO_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("zdso check failed");

`endif

// ----- hw/rtl/zdso_pkg.sv -----
`timescale 1ns / 1ps

package zdso_pkg;

   localparam int ZONE_COUNT = 8;
   localparam int ENTRY_COUNT = 2 * ZONE_COUNT;

   localparam int TRACK_WIDTH = 12;
   localparam int SECTOR_WIDTH = 8;
   localparam int ZONE_WIDTH = 3;
   localparam int ENTRY_WIDTH = 4;
   localparam int IN_BLOCK_WIDTH = 7;
   localparam int BLOCK_BYTES_WIDTH = 16;
   localparam int START_WIDTH = 27;
   localparam int TRACK_BYTES_WIDTH = BLOCK_BYTES_WIDTH + TRACK_WIDTH;
   localparam int SECTOR_BYTES_WIDTH = 16;
   localparam int OFFSET_WIDTH = 32;

   localparam int DISK_TYPE_WIDTH = 3;
   localparam int SECTOR_SIZE_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISK_TYPE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECTOR_SIZE = 1'b1;

   localparam logic [SECTOR_WIDTH-1:0] SECTORS_PER_BLOCK = 8'h5A;
   localparam logic [SECTOR_WIDTH-1:0] SECTORS_TWO_BLOCKS = 8'hB4;

   localparam logic [TRACK_WIDTH-1:0] ZONE_FIRST_TRACK [ZONE_COUNT] = '{
      12'h000, 12'h09E, 12'h13C, 12'h1D1, 12'h266, 12'h2FB, 12'h390, 12'h425
   };

   localparam logic [START_WIDTH-1:0] ZONE_START [ENTRY_COUNT] = '{
      27'h0000000, 27'h05F15E0, 27'h0B79D00, 27'h10801A0,
      27'h1523720, 27'h1963D80, 27'h1D414C0, 27'h20BBCE0,
      27'h23196E0, 27'h28A1E00, 27'h2DF5DC0, 27'h3299340,
      27'h36D99A0, 27'h3AB70E0, 27'h3E31900, 27'h4149200
   };

   localparam logic [BLOCK_BYTES_WIDTH-1:0] ZONE_BLOCK_BYTES [ENTRY_COUNT] = '{
      16'h4D08, 16'h47B8, 16'h4510, 16'h3FC0, 16'h3A70, 16'h3520, 16'h2FD0, 16'h2A80,
      16'h47B8, 16'h4510, 16'h3FC0, 16'h3A70, 16'h3520, 16'h2FD0, 16'h2A80, 16'h2530
   };

   typedef struct packed {
      logic [TRACK_WIDTH-1:0]  track_number;
      logic                    head_select;
      logic [SECTOR_WIDTH-1:0] sector_index;
   } req_word_type;

   typedef struct packed {
      logic [START_WIDTH-1:0]        zone_start;
      logic [TRACK_BYTES_WIDTH-1:0]  track_bytes;
      logic [BLOCK_BYTES_WIDTH-1:0]  block_bytes;
      logic [SECTOR_BYTES_WIDTH-1:0] sector_bytes;
      logic                          rom_area;
   } mid_word_type;

endpackage

// ----- hw/rtl/zdso_map.sv -----
`timescale 1ns / 1ps

module zdso_map (
   input  zdso_pkg::req_word_type                       word,
   input  logic [zdso_pkg::DISK_TYPE_WIDTH-1:0]         disk_type,
   input  logic [zdso_pkg::SECTOR_SIZE_WIDTH-1:0]       sector_size_minus_one,
   output zdso_pkg::mid_word_type                       mid
);

   logic [zdso_pkg::ZONE_WIDTH-1:0]         zone;
   logic [zdso_pkg::TRACK_WIDTH-1:0]        rel_track;
   logic [zdso_pkg::ENTRY_WIDTH-1:0]        entry;
   logic [zdso_pkg::BLOCK_BYTES_WIDTH-1:0]  bsize;
   logic                                    block;
   logic [zdso_pkg::SECTOR_WIDTH-1:0]       in_block_wide;
   logic [zdso_pkg::IN_BLOCK_WIDTH-1:0]     in_block;
   logic [zdso_pkg::SECTOR_SIZE_WIDTH:0]    sector_size;

   // zone is the number of thresholds reached
   always_comb begin
      zone = '0;
      for (int i = 1; i < zdso_pkg::ZONE_COUNT; i++) begin
         if (word.track_number >= zdso_pkg::ZONE_FIRST_TRACK[i]) begin
            zone = zone + 3'd1;
         end
      end
   end

   assign rel_track = word.track_number - zdso_pkg::ZONE_FIRST_TRACK[zone];
   assign entry = {word.head_select, zone};
   assign bsize = zdso_pkg::ZONE_BLOCK_BYTES[entry];

   // sector split modulo 90, with indices past two blocks folded once more
   always_comb begin
      block = (word.sector_index >= zdso_pkg::SECTORS_PER_BLOCK);
      if (word.sector_index >= zdso_pkg::SECTORS_TWO_BLOCKS) begin
         in_block_wide = word.sector_index - zdso_pkg::SECTORS_TWO_BLOCKS;
      end else if (block) begin
         in_block_wide = word.sector_index - zdso_pkg::SECTORS_PER_BLOCK;
      end else begin
         in_block_wide = word.sector_index;
      end
   end

   assign in_block = in_block_wide[zdso_pkg::IN_BLOCK_WIDTH-1:0];
   assign sector_size = {1'b0, sector_size_minus_one} + 9'd1;

   always_comb begin
      mid.zone_start = zdso_pkg::ZONE_START[entry];
      mid.track_bytes = zdso_pkg::TRACK_BYTES_WIDTH'(bsize)
                      * zdso_pkg::TRACK_BYTES_WIDTH'(rel_track);
      mid.block_bytes = block ? bsize : '0;
      mid.sector_bytes = zdso_pkg::SECTOR_BYTES_WIDTH'(in_block)
                       * zdso_pkg::SECTOR_BYTES_WIDTH'(sector_size);
      mid.rom_area = (({1'b0, zone} + {3'b000, word.head_select})
                     <= ({1'b0, disk_type} + 4'd2));
   end

endmodule

// ----- hw/rtl/zdso_sum.sv -----
`timescale 1ns / 1ps

module zdso_sum (
   input  zdso_pkg::mid_word_type                 mid,
   output logic [zdso_pkg::OFFSET_WIDTH-1:0]      byte_offset
);

   // two blocks per track in the zone, so the track term is doubled
   assign byte_offset = zdso_pkg::OFFSET_WIDTH'(mid.zone_start)
                      + {3'b000, mid.track_bytes, 1'b0}
                      + zdso_pkg::OFFSET_WIDTH'(mid.block_bytes)
                      + zdso_pkg::OFFSET_WIDTH'(mid.sector_bytes);

endmodule

// ----- hw/rtl/zoned_disk_sector_offset.sv -----
`timescale 1ns / 1ps

// Maps a track, head and sector of a zoned-recording disk to the byte offset
// of that sector in the disk image, plus a read-only area flag. Three register
// stages: input word, table lookup with the two products, final sum. An
// accepted word passes through all three registers before its result shows;
// one word is taken every cycle, and a waiting result stalls the input only
// once all three stages are full. Write disk_type and sector_size_minus_one
// only while no word is in flight.

module zoned_disk_sector_offset (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [zdso_pkg::TRACK_WIDTH-1:0]         req_track_number,
   input  logic                                     req_head_select,
   input  logic [zdso_pkg::SECTOR_WIDTH-1:0]        req_sector_index,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [zdso_pkg::OFFSET_WIDTH-1:0]        rsp_byte_offset,
   output logic                                     rsp_rom_area,
   input  logic                                     csr_write_enable,
   input  logic [zdso_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [zdso_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);

   logic [zdso_pkg::DISK_TYPE_WIDTH-1:0]   disk_type_ff;
   logic [zdso_pkg::SECTOR_SIZE_WIDTH-1:0] sector_size_ff;

   logic                    s1_valid_ff, s1_valid_in;
   zdso_pkg::req_word_type  s1_word_ff, s1_word_in;
   logic                    s2_valid_ff, s2_valid_in;
   zdso_pkg::mid_word_type  s2_mid_ff, s2_mid_in;
   logic                    s3_valid_ff, s3_valid_in;
   logic [zdso_pkg::OFFSET_WIDTH-1:0] s3_offset_ff, s3_offset_in;
   logic                    s3_rom_ff, s3_rom_in;

   logic ready1, ready2, ready3;

   zdso_pkg::mid_word_type            map_mid;
   logic [zdso_pkg::OFFSET_WIDTH-1:0] sum_offset;

   // a stage loads when empty or when its word moves on
   assign ready3 = !s3_valid_ff || !rsp_stall;
   assign ready2 = !s2_valid_ff || ready3;
   assign ready1 = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   zdso_map u_map (
      .word                  (s1_word_ff),
      .disk_type             (disk_type_ff),
      .sector_size_minus_one (sector_size_ff),
      .mid                   (map_mid)
   );

   zdso_sum u_sum (
      .mid         (s2_mid_ff),
      .byte_offset (sum_offset)
   );

   always_comb begin
      s1_valid_in = ready1 ? req_valid : s1_valid_ff;
      s1_word_in = s1_word_ff;
      if (ready1 && req_valid) begin
         s1_word_in.track_number = req_track_number;
         s1_word_in.head_select = req_head_select;
         s1_word_in.sector_index = req_sector_index;
      end

      s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;
      s2_mid_in = (ready2 && s1_valid_ff) ? map_mid : s2_mid_ff;

      s3_valid_in = ready3 ? s2_valid_ff : s3_valid_ff;
      s3_offset_in = (ready3 && s2_valid_ff) ? sum_offset : s3_offset_ff;
      s3_rom_in = (ready3 && s2_valid_ff) ? s2_mid_ff.rom_area : s3_rom_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      s2_mid_ff <= s2_mid_in;
      s3_offset_ff <= s3_offset_in;
      s3_rom_ff <= s3_rom_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         disk_type_ff <= '0;
         sector_size_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            zdso_pkg::CSR_DISK_TYPE: begin
               disk_type_ff <= csr_write_data[zdso_pkg::DISK_TYPE_WIDTH-1:0];
            end
            zdso_pkg::CSR_SECTOR_SIZE: begin
               sector_size_ff <= csr_write_data[zdso_pkg::SECTOR_SIZE_WIDTH-1:0];
            end
            default: begin
               disk_type_ff <= disk_type_ff;
            end
         endcase
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_byte_offset = s3_offset_ff;
   assign rsp_rom_area = s3_rom_ff;

endmodule

// ----- hw/rtl/zdso_checker.sv -----
`timescale 1ns / 1ps

`include "zoned_disk_sector_offset_assert.svh"

module zdso_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [zdso_pkg::OFFSET_WIDTH-1:0]    rsp_byte_offset,
   input logic                                 rsp_rom_area
);

   // a stalled result word stays offered
   `ZDSO_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)

   // and its payload does not move
   `ZDSO_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_byte_offset) && $stable(rsp_rom_area))

   // input only backs up behind a stalled result
   `ZDSO_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // an accepted word reaches the output within the pipe depth while rsp_stall stays low
   `ZDSO_ASSERT_NEXT(a_latency,
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind zoned_disk_sector_offset zdso_checker u_checker (.*);
